@@ rtl/core/fdl_pkg.sv @@
// Shared constants, types and codes for the fractional feedback delay line.
// No dependencies; every other file of the block but fdl_ram uses this package.
`timescale 1ns / 1ps

package fdl_pkg;

   // Ring depth and sample width.
   localparam int MAX_DELAY   = 131072;
   localparam int SAMPLE_BITS = 24;

   localparam int ADDR_BITS = $clog2(MAX_DELAY);
   localparam int LEN_BITS  = $clog2(MAX_DELAY + 1);

   // Register field widths.
   localparam int CFG_LEN_BITS = 18;
   localparam int FRAC_BITS    = 16;
   localparam int GAIN_BITS    = 16;
   localparam int COEF_BITS    = 17;

   localparam int PADDR_BITS = 4;
   localparam int PDATA_BITS = 32;

   // Shared multiplier operand and product widths.
   localparam int MUL_A_BITS = COEF_BITS + 1;
   localparam int MUL_B_BITS = SAMPLE_BITS + 1;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
   localparam int ACC_BITS   = PROD_BITS + 2;

   localparam int MIX_SHIFT = 16;
   localparam int FB_SHIFT  = 15;

   localparam logic signed [ACC_BITS-1:0] ROUND_MIX = ACC_BITS'(1) <<< (MIX_SHIFT - 1);
   localparam logic signed [ACC_BITS-1:0] ROUND_FB  = ACC_BITS'(1) <<< (FB_SHIFT - 1);

   localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << MIX_SHIFT;

   localparam logic signed [ACC_BITS-1:0] SAMPLE_HI = (ACC_BITS'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam logic signed [ACC_BITS-1:0] SAMPLE_LO = -(ACC_BITS'(1) <<< (SAMPLE_BITS - 1));

   typedef enum logic [1:0] {
      REG_DELAY_LENGTH,
      REG_DELAY_FRAC,
      REG_FEEDBACK_GAIN,
      REG_SMOOTHING_COEF
   } fdl_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_OLD,
      ST_RD_NEXT,
      ST_INTERP,
      ST_DELAY,
      ST_FEEDBACK,
      ST_WRITE,
      ST_SMOOTH
   } fdl_state_type;

   // Effective settings, already clamped to their legal ranges.
   typedef struct packed {
      logic [LEN_BITS-1:0]         length;
      logic [FRAC_BITS-1:0]        frac;
      logic signed [GAIN_BITS-1:0] gain;
      logic [COEF_BITS-1:0]        coef;
   } fdl_cfg_type;

   typedef struct packed {
      logic                         en;
      logic signed [MUL_A_BITS-1:0] a;
      logic signed [MUL_B_BITS-1:0] b;
   } fdl_mul_op_type;

endpackage

@@ rtl/core/fdl_req_if.sv @@
// Input channel of the delay line: one audio sample per beat.
// Depends on fdl_pkg for the sample width.
`timescale 1ns / 1ps

interface fdl_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [fdl_pkg::SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

@@ rtl/core/fdl_rsp_if.sv @@
// Result channel of the delay line: delayed and smoothed sample per beat.
// Depends on fdl_pkg for the sample width.
`timescale 1ns / 1ps

interface fdl_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [fdl_pkg::SAMPLE_BITS-1:0] delayed_out;
   logic signed [fdl_pkg::SAMPLE_BITS-1:0] smoothed_out;

   modport source (output valid, output delayed_out, output smoothed_out, input ready);
   modport sink (input valid, input delayed_out, input smoothed_out, output ready);
endinterface

@@ rtl/core/fdl_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module fdl_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/fdl_mul.sv @@
// Shared signed multiplier with a registered product, used for all three
// products of one sample. Depends on fdl_pkg for operand types.
`timescale 1ns / 1ps

module fdl_mul (
   input  logic                                 clock,
   input  fdl_pkg::fdl_mul_op_type              op,
   output logic signed [fdl_pkg::PROD_BITS-1:0] prod
);

   logic signed [fdl_pkg::PROD_BITS-1:0] prod_ff;
   logic signed [fdl_pkg::PROD_BITS-1:0] prod_in;

   assign prod_in = fdl_pkg::PROD_BITS'(op.a) * fdl_pkg::PROD_BITS'(op.b);

   // The product holds while no new operation is issued.
   always_ff @(posedge clock) begin
      if (op.en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

@@ rtl/core/fdl_csr.sv @@
// Configuration registers behind the APB-style port, with range clamping
// of the length and smoothing weight. Depends on fdl_pkg.
`timescale 1ns / 1ps

module fdl_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [fdl_pkg::PADDR_BITS-1:0]  paddr,
   input  logic [fdl_pkg::PDATA_BITS-1:0]  pwdata,
   output logic [fdl_pkg::PDATA_BITS-1:0]  prdata,
   output fdl_pkg::fdl_cfg_type            cfg
);

   logic [fdl_pkg::CFG_LEN_BITS-1:0] length_ff, length_in;
   logic [fdl_pkg::FRAC_BITS-1:0]    frac_ff, frac_in;
   logic [fdl_pkg::GAIN_BITS-1:0]    gain_ff, gain_in;
   logic [fdl_pkg::COEF_BITS-1:0]    coef_ff, coef_in;

   fdl_pkg::fdl_reg_type reg_sel;
   logic                 wr_stb;
   logic [31:0]          length_wide;

   assign reg_sel = fdl_pkg::fdl_reg_type'(paddr[3:2]);
   assign wr_stb  = psel && penable && pwrite;

   always_comb begin
      length_in = length_ff;
      frac_in   = frac_ff;
      gain_in   = gain_ff;
      coef_in   = coef_ff;
      prdata    = '0;
      case (reg_sel)
         fdl_pkg::REG_DELAY_LENGTH: begin
            prdata = fdl_pkg::PDATA_BITS'(length_ff);
            if (wr_stb) length_in = pwdata[fdl_pkg::CFG_LEN_BITS-1:0];
         end
         fdl_pkg::REG_DELAY_FRAC: begin
            prdata = fdl_pkg::PDATA_BITS'(frac_ff);
            if (wr_stb) frac_in = pwdata[fdl_pkg::FRAC_BITS-1:0];
         end
         fdl_pkg::REG_FEEDBACK_GAIN: begin
            prdata = fdl_pkg::PDATA_BITS'($signed(gain_ff));
            if (wr_stb) gain_in = pwdata[fdl_pkg::GAIN_BITS-1:0];
         end
         fdl_pkg::REG_SMOOTHING_COEF: begin
            prdata = fdl_pkg::PDATA_BITS'(coef_ff);
            if (wr_stb) coef_in = pwdata[fdl_pkg::COEF_BITS-1:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= fdl_pkg::CFG_LEN_BITS'(1);
         frac_ff   <= '0;
         gain_ff   <= '0;
         coef_ff   <= fdl_pkg::COEF_BITS'(32768);
      end else begin
         length_ff <= length_in;
         frac_ff   <= frac_in;
         gain_ff   <= gain_in;
         coef_ff   <= coef_in;
      end
   end

   // A length of zero behaves as one; anything past the ring depth as the depth.
   assign length_wide = 32'(length_ff);

   always_comb begin
      if (length_wide == 32'd0) begin
         cfg.length = fdl_pkg::LEN_BITS'(1);
      end else if (length_wide > 32'(fdl_pkg::MAX_DELAY)) begin
         cfg.length = fdl_pkg::LEN_BITS'(fdl_pkg::MAX_DELAY);
      end else begin
         cfg.length = fdl_pkg::LEN_BITS'(length_wide);
      end
      cfg.frac = frac_ff;
      cfg.gain = $signed(gain_ff);
      cfg.coef = (coef_ff > fdl_pkg::COEF_ONE) ? fdl_pkg::COEF_ONE : coef_ff;
   end

endmodule

@@ rtl/core/fdl_seq.sv @@
// Sequencer and datapath of the delay line: ring addressing, the three
// multiply-and-round steps on the shared multiplier, and the result register.
// Depends on fdl_pkg; drives fdl_mul and the ring fdl_ram from the top level.
`timescale 1ns / 1ps

module fdl_seq (
   input  logic                                   clock,
   input  logic                                   reset,
   input  fdl_pkg::fdl_cfg_type                   cfg,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [fdl_pkg::SAMPLE_BITS-1:0] sample_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [fdl_pkg::SAMPLE_BITS-1:0] delayed_out,
   output logic signed [fdl_pkg::SAMPLE_BITS-1:0] smoothed_out,
   output fdl_pkg::fdl_mul_op_type                mul_op,
   input  logic signed [fdl_pkg::PROD_BITS-1:0]   prod,
   output logic                                   ram_wr_en,
   output logic [fdl_pkg::ADDR_BITS-1:0]          ram_wr_addr,
   output logic [fdl_pkg::SAMPLE_BITS-1:0]        ram_wr_data,
   output logic [fdl_pkg::ADDR_BITS-1:0]          ram_rd_addr,
   input  logic [fdl_pkg::SAMPLE_BITS-1:0]        ram_rd_data
);

   fdl_pkg::fdl_state_type state_ff, state_in;

   logic [fdl_pkg::ADDR_BITS-1:0] widx_ff, widx_in;
   logic [fdl_pkg::LEN_BITS-1:0]  fill_ff, fill_in;
   logic signed [fdl_pkg::SAMPLE_BITS-1:0] last_ff, last_in;
   logic out_valid_ff, out_valid_in;

   logic [fdl_pkg::ADDR_BITS-1:0] idx_ff, idx_in;
   logic [fdl_pkg::ADDR_BITS-1:0] next_ff, next_in;
   logic signed [fdl_pkg::SAMPLE_BITS-1:0] x_ff, x_in;
   logic old_ok_ff, old_ok_in;
   logic next_ok_ff, next_ok_in;
   logic signed [fdl_pkg::SAMPLE_BITS-1:0] oldest_ff, oldest_in;
   logic signed [fdl_pkg::SAMPLE_BITS-1:0] second_ff, second_in;
   logic signed [fdl_pkg::SAMPLE_BITS-1:0] delayed_ff, delayed_in;
   logic signed [fdl_pkg::SAMPLE_BITS-1:0] dout_ff, dout_in;
   logic signed [fdl_pkg::SAMPLE_BITS-1:0] sout_ff, sout_in;

   logic [fdl_pkg::ADDR_BITS-1:0] start_idx;
   logic [fdl_pkg::LEN_BITS-1:0]  start_next;
   logic signed [fdl_pkg::SAMPLE_BITS-1:0] second_rd;
   logic signed [fdl_pkg::ACC_BITS-1:0] acc;
   logic signed [fdl_pkg::ACC_BITS-1:0] fb_sum;
   logic signed [fdl_pkg::SAMPLE_BITS-1:0] written;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fdl_pkg::ST_IDLE;
         widx_ff      <= '0;
         fill_ff      <= '0;
         last_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         widx_ff      <= widx_in;
         fill_ff      <= fill_in;
         last_ff      <= last_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      next_ff    <= next_in;
      x_ff       <= x_in;
      old_ok_ff  <= old_ok_in;
      next_ok_ff <= next_ok_in;
      oldest_ff  <= oldest_in;
      second_ff  <= second_in;
      delayed_ff <= delayed_in;
      dout_ff    <= dout_in;
      sout_ff    <= sout_in;
   end

   // A write index left beyond a shortened ring restarts at entry zero.
   always_comb begin
      if (fdl_pkg::LEN_BITS'(widx_ff) >= cfg.length) begin
         start_idx = '0;
      end else begin
         start_idx = widx_ff;
      end
      start_next = fdl_pkg::LEN_BITS'(start_idx) + fdl_pkg::LEN_BITS'(1);
   end

   // Entries at or above the fill mark were never written and read as zero.
   assign second_rd = next_ok_ff ? $signed(ram_rd_data) : '0;

   always_comb begin
      state_in     = state_ff;
      widx_in      = widx_ff;
      fill_in      = fill_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      idx_in       = idx_ff;
      next_in      = next_ff;
      x_in         = x_ff;
      old_ok_in    = old_ok_ff;
      next_ok_in   = next_ok_ff;
      oldest_in    = oldest_ff;
      second_in    = second_ff;
      delayed_in   = delayed_ff;
      dout_in      = dout_ff;
      sout_in      = sout_ff;

      req_ready   = 1'b0;
      mul_op      = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = '0;
      ram_rd_addr = next_ff;
      acc         = '0;
      fb_sum      = '0;
      written     = '0;

      case (state_ff)
         fdl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               idx_in = start_idx;
               if (start_next >= cfg.length) begin
                  next_in = '0;
               end else begin
                  next_in = fdl_pkg::ADDR_BITS'(start_next);
               end
               x_in     = sample_in;
               state_in = fdl_pkg::ST_RD_OLD;
            end
         end
         fdl_pkg::ST_RD_OLD: begin
            ram_rd_addr = idx_ff;
            old_ok_in   = fdl_pkg::LEN_BITS'(idx_ff) < fill_ff;
            state_in    = fdl_pkg::ST_RD_NEXT;
         end
         fdl_pkg::ST_RD_NEXT: begin
            ram_rd_addr = next_ff;
            oldest_in   = old_ok_ff ? $signed(ram_rd_data) : '0;
            next_ok_in  = fdl_pkg::LEN_BITS'(next_ff) < fill_ff;
            state_in    = fdl_pkg::ST_INTERP;
         end
         fdl_pkg::ST_INTERP: begin
            // frac*oldest + (1-frac)*second is second + frac*(oldest - second).
            second_in = second_rd;
            mul_op.en = 1'b1;
            mul_op.a  = $signed(fdl_pkg::MUL_A_BITS'(cfg.frac));
            mul_op.b  = fdl_pkg::MUL_B_BITS'(oldest_ff) - fdl_pkg::MUL_B_BITS'(second_rd);
            state_in  = fdl_pkg::ST_DELAY;
         end
         fdl_pkg::ST_DELAY: begin
            acc = (fdl_pkg::ACC_BITS'(second_ff) <<< fdl_pkg::MIX_SHIFT)
                  + fdl_pkg::ACC_BITS'(prod) + fdl_pkg::ROUND_MIX;
            delayed_in = fdl_pkg::SAMPLE_BITS'(acc >>> fdl_pkg::MIX_SHIFT);
            state_in   = fdl_pkg::ST_FEEDBACK;
         end
         fdl_pkg::ST_FEEDBACK: begin
            mul_op.en = 1'b1;
            mul_op.a  = fdl_pkg::MUL_A_BITS'(cfg.gain);
            mul_op.b  = fdl_pkg::MUL_B_BITS'(delayed_ff);
            state_in  = fdl_pkg::ST_WRITE;
         end
         fdl_pkg::ST_WRITE: begin
            acc    = (fdl_pkg::ACC_BITS'(prod) + fdl_pkg::ROUND_FB) >>> fdl_pkg::FB_SHIFT;
            fb_sum = fdl_pkg::ACC_BITS'(x_ff) + acc;
            if (fb_sum > fdl_pkg::SAMPLE_HI) begin
               written = fdl_pkg::SAMPLE_BITS'(fdl_pkg::SAMPLE_HI);
            end else if (fb_sum < fdl_pkg::SAMPLE_LO) begin
               written = fdl_pkg::SAMPLE_BITS'(fdl_pkg::SAMPLE_LO);
            end else begin
               written = fdl_pkg::SAMPLE_BITS'(fb_sum);
            end
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = written;
            if (fdl_pkg::LEN_BITS'(idx_ff) >= fill_ff) begin
               fill_in = fdl_pkg::LEN_BITS'(idx_ff) + fdl_pkg::LEN_BITS'(1);
            end
            // Smoothing: last + coef*(delayed - last).
            mul_op.en = 1'b1;
            mul_op.a  = $signed(fdl_pkg::MUL_A_BITS'(cfg.coef));
            mul_op.b  = fdl_pkg::MUL_B_BITS'(delayed_ff) - fdl_pkg::MUL_B_BITS'(last_ff);
            state_in  = fdl_pkg::ST_SMOOTH;
         end
         fdl_pkg::ST_SMOOTH: begin
            // Hold here until the result register is free.
            if (!out_valid_ff || rsp_ready) begin
               acc = (fdl_pkg::ACC_BITS'(last_ff) <<< fdl_pkg::MIX_SHIFT)
                     + fdl_pkg::ACC_BITS'(prod) + fdl_pkg::ROUND_MIX;
               sout_in      = fdl_pkg::SAMPLE_BITS'(acc >>> fdl_pkg::MIX_SHIFT);
               dout_in      = delayed_ff;
               out_valid_in = 1'b1;
               last_in      = delayed_ff;
               widx_in      = next_ff;
               state_in     = fdl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fdl_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid    = out_valid_ff;
   assign delayed_out  = dout_ff;
   assign smoothed_out = sout_ff;

endmodule

@@ rtl/core/fractional_feedback_delay_line.sv @@
// Fractional feedback delay line (feedback comb filter with linear
// interpolation). Each sample beat runs these steps from acceptance
// until the block is ready again: an accept step, then reads of the
// two oldest ring entries through the single read port of the ring memory,
// and three passes through one shared multiplier (interpolation, feedback,
// smoothing), each followed by a round-and-add step. The smoothing product
// is issued in the same cycle as the feedback round and the ring write, so
// that pass overlaps the feedback round. The result is registered, so
// the next sample is taken while it waits; only a result still unread
// when the following one is finished stalls the sequencer. Ring entries
// never written read as zero by way of a fill mark, so no clearing pass
// runs after reset. Configuration registers may be written only while no
// sample is in flight.
`timescale 1ns / 1ps

module fractional_feedback_delay_line (
   input  logic                           clock,
   input  logic                           reset,
   fdl_req_if.sink                        req,
   fdl_rsp_if.source                      rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [fdl_pkg::PADDR_BITS-1:0] paddr,
   input  logic [fdl_pkg::PDATA_BITS-1:0] pwdata,
   output logic [fdl_pkg::PDATA_BITS-1:0] prdata,
   output logic                           pready
);

   fdl_pkg::fdl_cfg_type                 cfg;
   fdl_pkg::fdl_mul_op_type              mul_op;
   logic signed [fdl_pkg::PROD_BITS-1:0] prod;
   logic                                 ram_wr_en;
   logic [fdl_pkg::ADDR_BITS-1:0]        ram_wr_addr;
   logic [fdl_pkg::SAMPLE_BITS-1:0]      ram_wr_data;
   logic [fdl_pkg::ADDR_BITS-1:0]        ram_rd_addr;
   logic [fdl_pkg::SAMPLE_BITS-1:0]      ram_rd_data;

   assign pready = 1'b1;

   fdl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   fdl_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req.valid),
      .req_ready    (req.ready),
      .sample_in    (req.sample_in),
      .rsp_valid    (rsp.valid),
      .rsp_ready    (rsp.ready),
      .delayed_out  (rsp.delayed_out),
      .smoothed_out (rsp.smoothed_out),
      .mul_op       (mul_op),
      .prod         (prod),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data)
   );

   fdl_mul u_mul (
      .clock (clock),
      .op    (mul_op),
      .prod  (prod)
   );

   fdl_ram #(
      .WIDTH (fdl_pkg::SAMPLE_BITS),
      .DEPTH (fdl_pkg::MAX_DELAY)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

@@ rtl/core/fdl_checker.sv @@
// Port-level checks for the fractional feedback delay line, bound to the top.
// Depends on fdl_pkg and on the top level fractional_feedback_delay_line.
`timescale 1ns / 1ps

module fdl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [fdl_pkg::SAMPLE_BITS-1:0] delayed_out,
   input logic [fdl_pkg::SAMPLE_BITS-1:0] smoothed_out,
   input logic                            pready
);

   // A sample beat keeps the block busy for the following cycles.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("input accepted again right after a sample beat");

   // A result is posted as the sequencer returns to idle.
   a_result_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result posted while the sequencer is still busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(delayed_out) && $stable(smoothed_out))
      else $error("stalled result beat changed or was dropped");

   a_reset_state: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid && pready)
      else $error("block not idle after reset");

endmodule

bind fractional_feedback_delay_line fdl_checker u_fdl_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .delayed_out  (rsp.delayed_out),
   .smoothed_out (rsp.smoothed_out),
   .pready       (pready)
);

@@ tb/sv/tb_fractional_feedback_delay_line.sv @@
// Self-checking testbench for fractional_feedback_delay_line: sample beats go in, APB writes
// change settings between phases; every result beat is checked against a model or typed row.
// Depends on fdl_pkg, fdl_req_if, fdl_rsp_if and the delay line itself.
`timescale 1ns / 1ps

module tb_fractional_feedback_delay_line;
   import fdl_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 650;
   localparam int SETTLE_CYCLES = 12;
   localparam int MAX_REPORTS   = 10;
   localparam int PLAN_ROWS     = 33;

   localparam longint SAT_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
   localparam longint SAT_LO = -SAT_HI - 1;

   typedef enum {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                  kind;
      fdl_reg_type                   csr_index;
      logic [PDATA_BITS-1:0]         value;
      logic signed [SAMPLE_BITS-1:0] sample;
      bit                            typed;
      logic signed [SAMPLE_BITS-1:0] exp_delayed;
      logic signed [SAMPLE_BITS-1:0] exp_smoothed;
   } stim_row_type;

   typedef struct {
      bit signed [SAMPLE_BITS-1:0] delayed;
      bit signed [SAMPLE_BITS-1:0] smoothed;
   } echo_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [PADDR_BITS-1:0] paddr;
   logic [PDATA_BITS-1:0] pwdata;
   logic [PDATA_BITS-1:0] prdata;
   logic                  pready;

   fdl_req_if req_bus();
   fdl_rsp_if rsp_bus();

   fractional_feedback_delay_line i_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Shadow copy of the settings and of the comb state.
   bit [CFG_LEN_BITS-1:0]       shadow_length = CFG_LEN_BITS'(1);
   bit [FRAC_BITS-1:0]          shadow_frac;
   bit signed [GAIN_BITS-1:0]   shadow_gain;
   bit [COEF_BITS-1:0]          shadow_coef = COEF_BITS'(32768);
   bit signed [SAMPLE_BITS-1:0] comb_ring [MAX_DELAY];
   int unsigned                 ring_pos;
   bit signed [SAMPLE_BITS-1:0] prev_delayed;

   echo_type echo_q [$];
   echo_type want;

   bit calm_stretch;
   int fail_count;
   int results_seen;
   int samples_sent;
   int random_sent;
   int csr_writes;
   int phases;
   int cycle_count;

   // Reset, saturating feedback at both gain extremes, then length, frac and coef corners.
   stim_row_type directed_plan [PLAN_ROWS] = '{
      '{ROW_SAMPLE, REG_DELAY_LENGTH,   32'h0,        24'sh7FFFFF, 1'b1, 24'sh000000, 24'sh000000},
      '{ROW_SAMPLE, REG_DELAY_LENGTH,   32'h0,        24'sh800000, 1'b1, 24'sh7FFFFF, 24'sh400000},
      '{ROW_SAMPLE, REG_DELAY_LENGTH,   32'h0,        24'sh000000, 1'b1, 24'sh800000, 24'sh000000},
      '{ROW_CSR,    REG_FEEDBACK_GAIN,  32'hFFFF8000, 24'sh000000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_SAMPLE, REG_DELAY_LENGTH,   32'h0,        24'sh7FFFFF, 1'b0, 24'sh0, 24'sh0},
      '{ROW_SAMPLE, REG_DELAY_LENGTH,   32'h0,        24'sh7FFFFF, 1'b0, 24'sh0, 24'sh0},
      '{ROW_SAMPLE, REG_DELAY_LENGTH,   32'h0,        24'sh800000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_SAMPLE, REG_DELAY_LENGTH,   32'h0,        24'sh7FFFFF, 1'b0, 24'sh0, 24'sh0},
      '{ROW_CSR,    REG_FEEDBACK_GAIN,  32'h00007FFF, 24'sh000000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_SAMPLE, REG_DELAY_LENGTH,   32'h0,        24'sh800000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_SAMPLE, REG_DELAY_LENGTH,   32'h0,        24'sh800000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_SAMPLE, REG_DELAY_LENGTH,   32'h0,        24'sh7FFFFF, 1'b0, 24'sh0, 24'sh0},
      '{ROW_CSR,    REG_DELAY_LENGTH,   32'h00000000, 24'sh000000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_SAMPLE, REG_DELAY_LENGTH,   32'h0,        24'sh123456, 1'b0, 24'sh0, 24'sh0},
      '{ROW_CSR,    REG_DELAY_LENGTH,   32'h00000003, 24'sh000000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_CSR,    REG_DELAY_FRAC,     32'h0000FFFF, 24'sh000000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_CSR,    REG_SMOOTHING_COEF, 32'h00010000, 24'sh000000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_SAMPLE, REG_DELAY_LENGTH,   32'h0,        24'sh000001, 1'b0, 24'sh0, 24'sh0},
      '{ROW_SAMPLE, REG_DELAY_LENGTH,   32'h0,        24'sh000002, 1'b0, 24'sh0, 24'sh0},
      '{ROW_SAMPLE, REG_DELAY_LENGTH,   32'h0,        24'shFFFFFF, 1'b0, 24'sh0, 24'sh0},
      '{ROW_SAMPLE, REG_DELAY_LENGTH,   32'h0,        24'sh400000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_SAMPLE, REG_DELAY_LENGTH,   32'h0,        24'sh000005, 1'b0, 24'sh0, 24'sh0},
      '{ROW_CSR,    REG_DELAY_LENGTH,   32'h00000002, 24'sh000000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_SAMPLE, REG_DELAY_LENGTH,   32'h0,        24'sh111111, 1'b0, 24'sh0, 24'sh0},
      '{ROW_CSR,    REG_SMOOTHING_COEF, 32'h0001FFFF, 24'sh000000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_CSR,    REG_DELAY_FRAC,     32'h00000000, 24'sh000000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_SAMPLE, REG_DELAY_LENGTH,   32'h0,        24'sh7FFFFF, 1'b0, 24'sh0, 24'sh0},
      '{ROW_SAMPLE, REG_DELAY_LENGTH,   32'h0,        24'sh800000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_CSR,    REG_DELAY_LENGTH,   32'h0003FFFF, 24'sh000000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_SAMPLE, REG_DELAY_LENGTH,   32'h0,        24'sh654321, 1'b0, 24'sh0, 24'sh0},
      '{ROW_SAMPLE, REG_DELAY_LENGTH,   32'h0,        24'shABCDEF, 1'b0, 24'sh0, 24'sh0},
      '{ROW_CSR,    REG_SMOOTHING_COEF, 32'h00000000, 24'sh000000, 1'b0, 24'sh0, 24'sh0},
      '{ROW_SAMPLE, REG_DELAY_LENGTH,   32'h0,        24'sh000000, 1'b0, 24'sh0, 24'sh0}
   };

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // One step of the interpolating comb: read the two oldest taps, mix, write back.
   function automatic void comb_step(input logic signed [SAMPLE_BITS-1:0] x,
                                     output echo_type e);
      int unsigned span;
      int unsigned nxt;
      longint      oldest;
      longint      second;
      longint      dly;
      longint      smo;
      longint      fb;
      longint      wr;
      longint      coef;
      span = shadow_length;
      if (span < 1) span = 1;
      if (span > MAX_DELAY) span = MAX_DELAY;
      if (ring_pos >= span) ring_pos = 0;
      nxt = ring_pos + 1;
      if (nxt >= span) nxt = 0;
      oldest = comb_ring[ring_pos];
      second = comb_ring[nxt];
      dly = (longint'(shadow_frac) * oldest
             + (65536 - longint'(shadow_frac)) * second + 32768) >>> 16;
      coef = (shadow_coef > 65536) ? 65536 : longint'(shadow_coef);
      smo = (coef * dly + (65536 - coef) * longint'(prev_delayed) + 32768) >>> 16;
      fb = (longint'(shadow_gain) * dly + 16384) >>> 15;
      wr = longint'(x) + fb;
      if (wr > SAT_HI) wr = SAT_HI;
      else if (wr < SAT_LO) wr = SAT_LO;
      comb_ring[ring_pos] = wr[SAMPLE_BITS-1:0];
      ring_pos = nxt;
      prev_delayed = dly[SAMPLE_BITS-1:0];
      e.delayed = dly[SAMPLE_BITS-1:0];
      e.smoothed = smo[SAMPLE_BITS-1:0];
   endfunction

   task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] x, input bit typed,
                              input echo_type typed_echo);
      echo_type predicted;
      @(negedge clock);
      while (!calm_stretch && $urandom_range(99) < 19) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.sample_in = x;
      do @(posedge clock); while (!req_bus.ready);
      comb_step(x, predicted);
      echo_q.push_back(typed ? typed_echo : predicted);
      samples_sent++;
   endtask

   // Stop sending and let every outstanding beat come back before touching the registers.
   task automatic drain_echoes();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (echo_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input fdl_reg_type idx, input logic [PDATA_BITS-1:0] value);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = PADDR_BITS'(int'(idx) * 4);
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_DELAY_LENGTH:   shadow_length = value[CFG_LEN_BITS-1:0];
         REG_DELAY_FRAC:     shadow_frac = value[FRAC_BITS-1:0];
         REG_FEEDBACK_GAIN:  shadow_gain = signed'(value[GAIN_BITS-1:0]);
         REG_SMOOTHING_COEF: shadow_coef = value[COEF_BITS-1:0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_bus.ready = calm_stretch || ($urandom_range(99) >= 19);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (echo_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("%0t: unexpected result beat: delayed %0d smoothed %0d", $time,
                        rsp_bus.delayed_out, rsp_bus.smoothed_out);
         end else begin
            want = echo_q.pop_front();
            if (rsp_bus.delayed_out !== want.delayed
                || rsp_bus.smoothed_out !== want.smoothed) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: beat %0d: delayed exp %0d got %0d, smoothed exp %0d got %0d",
                           $time, results_seen, want.delayed, rsp_bus.delayed_out,
                           want.smoothed, rsp_bus.smoothed_out);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d beats outstanding", cycle_count,
                  echo_q.size());
         $display("FAIL fractional_feedback_delay_line");
         $finish;
      end
   end

   initial begin
      echo_type                      typed_echo;
      echo_type                      no_echo;
      logic [PDATA_BITS-1:0]         word;
      logic signed [SAMPLE_BITS-1:0] x;
      int                            burst;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.sample_in = '0;
      no_echo = '{default: '0};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CSR) begin
            drain_echoes();
            write_csr(directed_plan[i].csr_index, directed_plan[i].value);
         end else begin
            typed_echo.delayed = directed_plan[i].exp_delayed;
            typed_echo.smoothed = directed_plan[i].exp_smoothed;
            push_sample(directed_plan[i].sample, directed_plan[i].typed, typed_echo);
         end
      end

      // Random phases: fresh settings while idle, then a burst of samples.
      while (random_sent < RANDOM_ITEMS) begin
         drain_echoes();
         phases++;
         calm_stretch = (phases == 3);

         case ($urandom_range(19))
            0:       word = 0;
            1:       word = 1;
            2:       word = 2;
            3:       word = MAX_DELAY;
            4:       word = $urandom_range(262143, MAX_DELAY + 1);
            default: word = $urandom_range(64, 1);
         endcase
         write_csr(REG_DELAY_LENGTH, word);

         case ($urandom_range(7))
            0:       word = 0;
            1:       word = 65535;
            2:       word = 32768;
            default: word = $urandom_range(65535);
         endcase
         write_csr(REG_DELAY_FRAC, word);

         case ($urandom_range(7))
            0:       word = 32'hFFFF8000;
            1:       word = 32'h00007FFF;
            2:       word = 0;
            default: begin
               word = $urandom_range(65535);
               word = {{16{word[15]}}, word[15:0]};
            end
         endcase
         write_csr(REG_FEEDBACK_GAIN, word);

         case ($urandom_range(7))
            0:       word = 0;
            1:       word = 65536;
            2:       word = 131071;
            3:       word = $urandom_range(131071, 65537);
            default: word = $urandom_range(65536);
         endcase
         write_csr(REG_SMOOTHING_COEF, word);

         burst = calm_stretch ? 60 : $urandom_range(60, 20);
         repeat (burst) begin
            if ($urandom_range(59) == 0) drain_echoes();
            case ($urandom_range(9))
               0:       x = 24'sh7FFFFF;
               1:       x = 24'sh800000;
               2, 3:    x = SAMPLE_BITS'($urandom_range(8191) - 4096);
               default: x = SAMPLE_BITS'($urandom);
            endcase
            push_sample(x, 1'b0, no_echo);
            random_sent++;
         end
      end
      calm_stretch = 1'b0;

      drain_echoes();
      repeat (20) @(posedge clock);

      $display("Covered %0d sample beats (%0d random) over %0d setting phases, %0d writes;",
               samples_sent, random_sent, phases, csr_writes);
      $display("%0d result beats checked, %0d failures.", results_seen, fail_count);
      if (fail_count == 0 && echo_q.size() == 0) begin
         $display("PASS fractional_feedback_delay_line");
      end else begin
         $display("FAIL fractional_feedback_delay_line");
      end
      $finish;
   end

endmodule
